/* rtl/atp_pkg.sv */
// Package with shared constants and the arctangent step table for the tilt pipeline.
`default_nettype none
package atp_pkg;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;
   localparam logic [15:0] RATE_GAIN_RESET = 16'd16009;

   function automatic logic [22:0] atan_step(input int idx);
      logic [22:0] val;
      case (idx)
         0: val = 23'd2949120;
         1: val = 23'd1740967;
         2: val = 23'd919879;
         3: val = 23'd466945;
         4: val = 23'd234379;
         5: val = 23'd117304;
         6: val = 23'd58666;
         7: val = 23'd29335;
         8: val = 23'd14668;
         9: val = 23'd7334;
         10: val = 23'd3667;
         11: val = 23'd1833;
         12: val = 23'd917;
         13: val = 23'd458;
         14: val = 23'd229;
         15: val = 23'd115;
         16: val = 23'd57;
         17: val = 23'd29;
         18: val = 23'd14;
         19: val = 23'd7;
         20: val = 23'd4;
         21: val = 23'd2;
         22: val = 23'd1;
         default: val = 23'd0;
      endcase
      return val;
   endfunction
endpackage
`default_nettype wire

/* rtl/atp_tilt.sv */
// Pipelined tilt angle: squares, digit-by-digit square root, vectoring CORDIC, rounding.
`default_nettype none
module atp_tilt import atp_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [15:0] num,
   input  wire logic signed [15:0] den_a,
   input  wire logic signed [15:0] den_b,
   output logic signed [15:0]      angle
);
   localparam int ROOT_BITS = 24;

   logic [31:0] sqa_ff, sqb_ff;
   logic signed [15:0] n0_ff;
   logic [47:0] rem_ff [0:ROOT_BITS];
   logic [23:0] q_ff [0:ROOT_BITS];
   logic signed [15:0] nq_ff [0:ROOT_BITS];
   logic signed [27:0] x_ff [0:CORDIC_STEPS-1];
   logic signed [27:0] y_ff [0:CORDIC_STEPS-1];
   logic signed [24:0] a_ff [0:CORDIC_STEPS-1];
   logic zd_ff [0:CORDIC_STEPS-1];
   logic np_ff [0:CORDIC_STEPS-1];
   logic nn_ff [0:CORDIC_STEPS-1];
   logic signed [15:0] angle_ff;
   logic signed [24:0] rnd_sum;
   logic signed [16:0] rnd;
   logic signed [15:0] angle_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         sqa_ff <= 32'(den_a * den_a);
         sqb_ff <= 32'(den_b * den_b);
         n0_ff <= num;
         rem_ff[0] <= {sqa_ff + sqb_ff, 16'd0};
         q_ff[0] <= '0;
         nq_ff[0] <= n0_ff;
      end
   end

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_sqrt
      localparam int K = ROOT_BITS - 1 - s;
      logic [48:0] test;
      logic take;
      always_comb begin
         test = ({25'd0, q_ff[s]} << (K + 1)) | (49'd1 << (2 * K));
         take = {1'b0, rem_ff[s]} >= test;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1] <= take ? 48'({1'b0, rem_ff[s]} - test) : rem_ff[s];
            q_ff[s+1] <= take ? (q_ff[s] | (24'd1 << K)) : q_ff[s];
            nq_ff[s+1] <= nq_ff[s];
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [27:0] xp, yp;
      logic signed [24:0] ap;
      logic zp, pp, ngp;
      always_comb begin
         if (i == 0) begin
            xp = $signed({4'd0, q_ff[ROOT_BITS]});
            yp = $signed({{4{nq_ff[ROOT_BITS][15]}}, nq_ff[ROOT_BITS], 8'd0});
            ap = '0;
            zp = q_ff[ROOT_BITS] == 24'd0;
            pp = nq_ff[ROOT_BITS] > 16'sd0;
            ngp = nq_ff[ROOT_BITS] < 16'sd0;
         end else begin
            xp = x_ff[(i > 0) ? i - 1 : 0];
            yp = y_ff[(i > 0) ? i - 1 : 0];
            ap = a_ff[(i > 0) ? i - 1 : 0];
            zp = zd_ff[(i > 0) ? i - 1 : 0];
            pp = np_ff[(i > 0) ? i - 1 : 0];
            ngp = nn_ff[(i > 0) ? i - 1 : 0];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!yp[27]) begin
               x_ff[i] <= xp + (yp >>> i);
               y_ff[i] <= yp - (xp >>> i);
               a_ff[i] <= ap + $signed({2'd0, atan_step(i)});
            end else begin
               x_ff[i] <= xp - (yp >>> i);
               y_ff[i] <= yp + (xp >>> i);
               a_ff[i] <= ap - $signed({2'd0, atan_step(i)});
            end
            zd_ff[i] <= zp;
            np_ff[i] <= pp;
            nn_ff[i] <= ngp;
         end
      end
   end

   always_comb begin
      rnd_sum = a_ff[CORDIC_STEPS-1] + 25'sd128;
      rnd = 17'(rnd_sum >>> 8);
      if (zd_ff[CORDIC_STEPS-1]) begin
         if (np_ff[CORDIC_STEPS-1]) begin
            angle_in = ANGLE_LIMIT;
         end else if (nn_ff[CORDIC_STEPS-1]) begin
            angle_in = -ANGLE_LIMIT;
         end else begin
            angle_in = '0;
         end
      end else if (rnd > 17'(ANGLE_LIMIT)) begin
         angle_in = ANGLE_LIMIT;
      end else if (rnd < -17'(ANGLE_LIMIT)) begin
         angle_in = -ANGLE_LIMIT;
      end else begin
         angle_in = rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;
endmodule
`default_nettype wire

/* rtl/accel_tilt_angle_and_gyro_rate.sv */
// Top level: tilt angles from accelerometer samples and scaled gyro rates.
//
// The req channel carries one inertial sample set per transfer; the rsp channel
// returns one result per set, in order. csr_we with csr_wdata writes the Q0.16
// gyro gain, which applies to sets accepted after the write.
// The first stage, the squares, loads at the edge that accepts a req transfer;
// then come one stage for their sum, 24 stages for the one-bit-per-stage square
// root, one per CORDIC step, one for rounding and one for the output register.
// Throughput is one set per cycle while the pipeline is not held by rsp_tready.
// All stages move together; when rsp_tvalid is high and rsp_tready low the whole
// pipeline holds and req_tready falls, so nothing is lost or repeated.
// Reset clears all valid bits and restores the gain to 16009 (65.5 LSB per deg/s).
`default_nettype none
module accel_tilt_angle_and_gyro_rate import atp_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   localparam int TILT_LAT = 27 + CORDIC_STEPS;
   localparam int LAT = TILT_LAT + 1;
   localparam int DLY = TILT_LAT - 2;

   logic enable;
   logic [15:0] gain_ff;
   logic [LAT-1:0] valid_ff;
   logic signed [15:0] ax, ay, az;
   logic signed [15:0] roll, pitch_pos;
   logic signed [32:0] prod_ff [0:2];
   logic [15:0] rate_ff [0:2];
   logic [47:0] dly_ff [0:DLY-1];
   logic [79:0] rsp_tdata_ff;

   assign enable = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata = rsp_tdata_ff;
   assign ax = req_tdata[15:0];
   assign ay = req_tdata[31:16];
   assign az = req_tdata[47:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= RATE_GAIN_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_we) begin
            gain_ff <= csr_wdata;
         end
         if (enable) begin
            valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
         end
      end
   end

   atp_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .enable(enable), .num(ay), .den_a(ax), .den_b(az), .angle(roll)
   );

   atp_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .enable(enable), .num(ax), .den_a(ay), .den_b(az), .angle(pitch_pos)
   );

   for (genvar g = 0; g < 3; g++) begin : g_rate
      logic signed [32:0] rsum;
      logic signed [16:0] rsh;
      logic [15:0] rsat;
      always_comb begin
         rsum = prod_ff[g] + 33'sd32768;
         rsh = 17'(rsum >>> 16);
         if (rsh > 17'sd32767) begin
            rsat = 16'h7fff;
         end else if (rsh < -17'sd32768) begin
            rsat = 16'h8000;
         end else begin
            rsat = rsh[15:0];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            prod_ff[g] <= $signed(req_tdata[48+16*g +: 16]) * $signed({1'b0, gain_ff});
            rate_ff[g] <= rsat;
         end
      end
   end

   for (genvar d = 0; d < DLY; d++) begin : g_dly
      always_ff @(posedge clock) begin
         if (enable) begin
            dly_ff[d] <= (d == 0) ? {rate_ff[2], rate_ff[1], rate_ff[0]}
                                  : dly_ff[(d > 0) ? d - 1 : 0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_tdata_ff <= {dly_ff[DLY-1], 16'(-pitch_pos), roll};
      end
   end
endmodule
`default_nettype wire

/* tb/tb_accel_tilt_angle_and_gyro_rate.sv */
// Self-checking testbench for the tilt angle and gyro rate pipeline.
`default_nettype none
module tb_accel_tilt_angle_and_gyro_rate;
   import atp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int LATENCY = 27 + STEPS;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] gyro_z;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_x;
      logic signed [15:0] acc_z;
      logic signed [15:0] acc_y;
      logic signed [15:0] acc_x;
   } sample_set_t;

   typedef struct packed {
      logic signed [15:0] yaw_rate;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } attitude_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   logic [15:0] gain_shadow = RATE_GAIN_RESET;
   attitude_t pending_attitudes[$];
   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int error_count = 0;
   int received_count = 0;
   longint cycle_count = 0;

   accel_tilt_angle_and_gyro_rate #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint atan_entry(int i);
      case (i)
         0: return 2949120;   1: return 1740967;  2: return 919879;  3: return 466945;
         4: return 234379;    5: return 117304;   6: return 58666;   7: return 29335;
         8: return 14668;     9: return 7334;     10: return 3667;   11: return 1833;
         12: return 917;      13: return 458;     14: return 229;    15: return 115;
         16: return 57;       17: return 29;      18: return 14;     19: return 7;
         20: return 4;        21: return 2;       22: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic logic [15:0] tilt_angle(longint n, longint a, longint b);
      longint x;
      longint y;
      longint ang;
      longint dx;
      longint dy;
      longint r;
      x = int_sqrt(longint'(a * a + b * b) << 16);
      y = n * 256;
      ang = 0;
      if (x == 0) begin
         if (n > 0) return 16'(23040);
         if (n < 0) return 16'(-23040);
         return 16'd0;
      end
      for (int i = 0; i < STEPS && i < ATAN_TABLE_LEN; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; ang += atan_entry(i);
         end else begin
            x -= dx; y += dy; ang -= atan_entry(i);
         end
      end
      r = shift_floor(ang + 128, 8);
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return 16'(r);
   endfunction

   function automatic logic [15:0] scaled_rate(logic signed [15:0] raw);
      longint r;
      r = shift_floor(longint'(raw) * longint'(gain_shadow) + 32768, 16);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic attitude_t predict_attitude(sample_set_t s);
      attitude_t a;
      a.roll_angle = tilt_angle(s.acc_y, s.acc_x, s.acc_z);
      a.pitch_angle = 16'(-longint'($signed(tilt_angle(s.acc_x, s.acc_y, s.acc_z))));
      a.roll_rate = scaled_rate(s.gyro_x);
      a.pitch_rate = scaled_rate(s.gyro_y);
      a.yaw_rate = scaled_rate(s.gyro_z);
      return a;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_accel_tilt_angle_and_gyro_rate: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      attitude_t got;
      attitude_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         received_count <= received_count + 1;
         if (pending_attitudes.size() == 0) begin
            $error("unexpected result transfer %h", got);
            error_count++;
         end else begin
            want = pending_attitudes.pop_front();
            if (got.roll_angle !== want.roll_angle) begin
               $error("roll_angle expected %0d got %0d", want.roll_angle, got.roll_angle);
               error_count++;
            end
            if (got.pitch_angle !== want.pitch_angle) begin
               $error("pitch_angle expected %0d got %0d", want.pitch_angle, got.pitch_angle);
               error_count++;
            end
            if (got.roll_rate !== want.roll_rate) begin
               $error("roll_rate expected %0d got %0d", want.roll_rate, got.roll_rate);
               error_count++;
            end
            if (got.pitch_rate !== want.pitch_rate) begin
               $error("pitch_rate expected %0d got %0d", want.pitch_rate, got.pitch_rate);
               error_count++;
            end
            if (got.yaw_rate !== want.yaw_rate) begin
               $error("yaw_rate expected %0d got %0d", want.yaw_rate, got.yaw_rate);
               error_count++;
            end
         end
      end
   end

   task automatic send_set(sample_set_t s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_attitudes.push_back(predict_attitude(s));
   endtask

   task automatic drain_and_write_gain(logic [15:0] gain);
      req_tvalid <= 1'b0;
      while (pending_attitudes.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= gain;
      @(posedge clock);
      csr_we <= 1'b0;
      gain_shadow = gain;
   endtask

   function automatic logic [15:0] edge_value(int k);
      case (k % 6)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed_cases();
      sample_set_t s;
      s = '0;
      send_set(s);
      s.acc_y = 16'sd100;
      send_set(s);
      s.acc_y = -16'sd100;
      send_set(s);
      s = '0;
      s.acc_x = 16'sd1;
      send_set(s);
      s.acc_x = -16'sd32768;
      send_set(s);
      s = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      send_set(s);
      s = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      send_set(s);
      s = '{16'hFFFF, 16'h0001, 16'h0000, 16'h4000, 16'hC000, 16'h0000};
      send_set(s);
      for (int k = 0; k < 14; k++) begin
         s = {edge_value(k + 5), edge_value(k + 4), edge_value(k + 3),
              edge_value(k + 2), edge_value(k + 1), edge_value(k)};
         send_set(s);
      end
   endtask

   task automatic test_random_sets(int count);
      sample_set_t s;
      for (int k = 0; k < count; k++) begin
         s = {$urandom, $urandom, $urandom};
         if ($urandom_range(3) == 0) s.acc_x = 16'($signed(16'($urandom_range(15))) - 8);
         if ($urandom_range(3) == 0) s.acc_z = 16'($signed(16'($urandom_range(15))) - 8);
         send_set(s);
      end
   endtask

   task automatic test_gain_settings();
      logic [15:0] gains[4] = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom)};
      foreach (gains[g]) begin
         drain_and_write_gain(gains[g]);
         test_random_sets(60);
      end
      drain_and_write_gain(RATE_GAIN_RESET);
   endtask

   task automatic test_flow_phases();
      int idle_pct[4] = '{0, 54, 0, 30};
      int stall_pct[4] = '{0, 0, 54, 30};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_pct[p];
         sink_stall_pct = stall_pct[p];
         test_random_sets(250);
      end
      send_idle_pct = 0;
      sink_stall_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_flow_phases();
      test_gain_settings();
      while (pending_attitudes.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d result transfers from directed extremes, random sets,", received_count);
      $display("four gain settings and four source and sink idling mixes.");
      if (error_count == 0) begin
         $display("tb_accel_tilt_angle_and_gyro_rate: clean");
      end else begin
         $display("tb_accel_tilt_angle_and_gyro_rate: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
